FILE: hdl/p1tf_pkg.sv
// ----------------------------------------------------------------------------
// p1tf_pkg
// Shared types, constants and functions of the meter-port telegram framer.
// ----------------------------------------------------------------------------
package p1tf_pkg;

   localparam int MAX_LEN_DEFAULT = 2048;
   localparam logic [11:0] MAX_LENGTH_RESET = 12'd1500;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_BANG = 8'h21;
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam int TAIL = 6;
   localparam logic [11:0] MIN_LENGTH = 12'd7;
   localparam logic [0:0] REG_MAX_LENGTH = 1'b0;

   typedef enum logic [1:0] {
      STATUS_GOOD     = 2'd0,
      STATUS_MISMATCH = 2'd1,
      STATUS_SHORT    = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ACT_NONE  = 2'd0,
      ACT_CLOSE = 2'd1,
      ACT_ABORT = 2'd2
   } action_type;

   typedef struct packed {
      logic        feed_valid;
      logic [7:0]  feed_byte;
      action_type  action;
      logic [11:0] length;
      logic [31:0] digits;
   } cmd_type;

   typedef struct packed {
      status_type  status;
      logic [11:0] length;
      logic [15:0] crc;
   } rsp_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'd0, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      logic [7:0] d;
      if (v < 4'd10) begin
         d = 8'h30 + {4'd0, v};
      end else begin
         d = 8'h37 + {4'd0, v};
      end
      return d;
   endfunction

endpackage

FILE: hdl/p1tf_fifo.sv
// ----------------------------------------------------------------------------
// p1tf_fifo
// Small synchronous first-in first-out queue of packed words.
// ----------------------------------------------------------------------------
module p1tf_fifo #(
   parameter int WIDTH = 8,
   parameter int ADDR_BITS = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int DEPTH = 1 << ADDR_BITS;

   logic [WIDTH-1:0] mem [DEPTH];
   logic [ADDR_BITS-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [ADDR_BITS:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == (ADDR_BITS + 1)'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign rdata = mem[rptr_ff];

   always_comb begin
      wptr_in = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: hdl/p1tf_front.sv
// ----------------------------------------------------------------------------
// p1tf_front
// Framing state, byte count and six-byte delay line; issues CRC, close and
// abort commands to the back end.
// ----------------------------------------------------------------------------
module p1tf_front #(
   parameter int MAX_LEN = p1tf_pkg::MAX_LEN_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         rx_byte,
   input  logic [11:0]        max_length,
   output logic               cmd_push,
   output p1tf_pkg::cmd_type  cmd
);

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_DATA = 2'd1,
      PH_END  = 2'd2
   } phase_type;

   localparam logic [12:0] LEN_CAP = (MAX_LEN > 4095) ? 13'd4095 : 13'(MAX_LEN);

   phase_type phase_ff, phase_in;
   logic [11:0] count_ff, count_in;
   logic [7:0] recent_ff [p1tf_pkg::TAIL];
   logic [7:0] recent_in [p1tf_pkg::TAIL];
   logic [12:0] limit;
   logic [12:0] count_next;

   always_comb begin
      limit = ({1'b0, max_length} > LEN_CAP) ? LEN_CAP : {1'b0, max_length};
      count_next = {1'b0, count_ff} + 13'd1;
      phase_in = phase_ff;
      count_in = count_ff;
      recent_in = recent_ff;
      cmd_push = 1'b0;
      cmd.feed_valid = 1'b0;
      cmd.feed_byte = recent_ff[p1tf_pkg::TAIL-1];
      cmd.action = p1tf_pkg::ACT_NONE;
      cmd.length = count_ff;
      cmd.digits = {recent_ff[4], recent_ff[3], recent_ff[2], recent_ff[1]};
      if (accept) begin
         case (phase_ff)
            PH_DATA, PH_END: begin
               if (count_next > limit) begin
                  cmd_push = 1'b1;
                  cmd.action = p1tf_pkg::ACT_ABORT;
                  phase_in = PH_IDLE;
                  count_in = '0;
                  for (int i = 0; i < p1tf_pkg::TAIL; i++) recent_in[i] = '0;
               end else begin
                  cmd.feed_valid = (count_ff >= 12'(p1tf_pkg::TAIL));
                  for (int i = p1tf_pkg::TAIL - 1; i > 0; i--) recent_in[i] = recent_ff[i-1];
                  recent_in[0] = rx_byte;
                  count_in = count_next[11:0];
                  if (phase_ff == PH_DATA) begin
                     if (rx_byte == p1tf_pkg::CHAR_BANG) begin
                        phase_in = PH_END;
                     end
                  end else if (recent_ff[0] == p1tf_pkg::CHAR_CR &&
                               rx_byte == p1tf_pkg::CHAR_LF) begin
                     cmd.action = p1tf_pkg::ACT_CLOSE;
                     cmd.length = count_next[11:0];
                     phase_in = PH_IDLE;
                     count_in = '0;
                     for (int i = 0; i < p1tf_pkg::TAIL; i++) recent_in[i] = '0;
                  end
                  cmd_push = cmd.feed_valid || (cmd.action != p1tf_pkg::ACT_NONE);
               end
            end
            default: begin
               phase_in = PH_IDLE;
               if (rx_byte == p1tf_pkg::CHAR_SLASH) begin
                  if (limit == '0) begin
                     cmd_push = 1'b1;
                     cmd.action = p1tf_pkg::ACT_ABORT;
                     cmd.length = '0;
                  end else begin
                     for (int i = 1; i < p1tf_pkg::TAIL; i++) recent_in[i] = '0;
                     recent_in[0] = rx_byte;
                     count_in = 12'd1;
                     phase_in = PH_DATA;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         for (int i = 0; i < p1tf_pkg::TAIL; i++) recent_ff[i] <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         recent_ff <= recent_in;
      end
   end

endmodule

FILE: hdl/p1tf_back.sv
// ----------------------------------------------------------------------------
// p1tf_back
// Runs the CRC over the delayed bytes and builds the close and abort results.
// ----------------------------------------------------------------------------
module p1tf_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_empty,
   input  p1tf_pkg::cmd_type  cmd,
   output logic               cmd_pop,
   input  logic               rsp_full,
   output logic               rsp_push,
   output p1tf_pkg::rsp_type  rsp
);

   logic [15:0] crc_ff, crc_in;
   logic [15:0] crc_next;
   logic match;

   always_comb begin
      crc_next = cmd.feed_valid ? p1tf_pkg::crc_byte(crc_ff, cmd.feed_byte) : crc_ff;
      match = cmd.digits == {p1tf_pkg::hex_digit(crc_next[15:12]),
                             p1tf_pkg::hex_digit(crc_next[11:8]),
                             p1tf_pkg::hex_digit(crc_next[7:4]),
                             p1tf_pkg::hex_digit(crc_next[3:0])};
      cmd_pop = !cmd_empty && (cmd.action == p1tf_pkg::ACT_NONE || !rsp_full);
      rsp_push = cmd_pop && (cmd.action != p1tf_pkg::ACT_NONE);
      rsp.length = cmd.length;
      rsp.crc = crc_next;
      if (cmd.action == p1tf_pkg::ACT_ABORT) begin
         rsp.status = p1tf_pkg::STATUS_OVERFLOW;
      end else if (cmd.length < p1tf_pkg::MIN_LENGTH) begin
         rsp.status = p1tf_pkg::STATUS_SHORT;
      end else if (match) begin
         rsp.status = p1tf_pkg::STATUS_GOOD;
      end else begin
         rsp.status = p1tf_pkg::STATUS_MISMATCH;
      end
      crc_in = crc_ff;
      if (cmd_pop) begin
         crc_in = rsp_push ? 16'd0 : crc_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= '0;
      end else begin
         crc_ff <= crc_in;
      end
   end

endmodule

FILE: hdl/p1_telegram_framer_crc_check.sv
// ----------------------------------------------------------------------------
// p1_telegram_framer_crc_check
// Frames meter-port telegrams from a byte stream and checks their CRC-16.
//
//   Channel   Direction  Handshake            Contents
//   req_      in         req_push / req_full  rx_byte
//   rsp_      out        rsp_empty / rsp_pop  status, telegram_length, crc
//   csr_      in/out     APB, pready high     max_telegram_length at 0x0
//
// One word is accepted per cycle while the command queue is not full; the front
// end, the command queue and the CRC step in the back end all run at one word per
// cycle. After the closing word a result passes the command queue, then the result queue.
// Reset clears the framer, the CRC and both queues and sets the limit to 1500.
// The input stalls only when the command queue fills behind a full result queue.
// ----------------------------------------------------------------------------
module p1_telegram_framer_crc_check #(
   parameter int MAX_LEN = p1tf_pkg::MAX_LEN_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_status,
   output logic [11:0] rsp_telegram_length,
   output logic [15:0] rsp_computed_crc,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [11:0] max_length_ff;
   logic reg_hit;
   logic accept;
   logic cmd_push, cmd_full, cmd_pop, cmd_empty;
   p1tf_pkg::cmd_type cmd_w, cmd_r;
   logic rsp_push, rsp_full;
   p1tf_pkg::rsp_type rsp_w, rsp_r;

   assign csr_pready = 1'b1;
   assign reg_hit = (csr_paddr[2] == p1tf_pkg::REG_MAX_LENGTH) && (csr_paddr[1:0] == 2'd0);
   assign csr_prdata = reg_hit ? {20'd0, max_length_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= p1tf_pkg::MAX_LENGTH_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && reg_hit) begin
         max_length_ff <= csr_pwdata[11:0];
      end
   end

   assign req_full = cmd_full;
   assign accept = req_push && !cmd_full;

   p1tf_front #(.MAX_LEN(MAX_LEN)) u_front (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .rx_byte(req_rx_byte),
      .max_length(max_length_ff),
      .cmd_push(cmd_push),
      .cmd(cmd_w)
   );

   p1tf_fifo #(.WIDTH($bits(p1tf_pkg::cmd_type)), .ADDR_BITS(2)) u_cmd_q (
      .clock(clock),
      .reset(reset),
      .push(cmd_push),
      .wdata(cmd_w),
      .full(cmd_full),
      .pop(cmd_pop),
      .rdata(cmd_r),
      .empty(cmd_empty)
   );

   p1tf_back u_back (
      .clock(clock),
      .reset(reset),
      .cmd_empty(cmd_empty),
      .cmd(cmd_r),
      .cmd_pop(cmd_pop),
      .rsp_full(rsp_full),
      .rsp_push(rsp_push),
      .rsp(rsp_w)
   );

   p1tf_fifo #(.WIDTH($bits(p1tf_pkg::rsp_type)), .ADDR_BITS(1)) u_rsp_q (
      .clock(clock),
      .reset(reset),
      .push(rsp_push),
      .wdata(rsp_w),
      .full(rsp_full),
      .pop(rsp_pop),
      .rdata(rsp_r),
      .empty(rsp_empty)
   );

   assign rsp_status = rsp_r.status;
   assign rsp_telegram_length = rsp_r.length;
   assign rsp_computed_crc = rsp_r.crc;

endmodule
